// ===== src/cgps_pkg.sv =====
package cgps_pkg;

	localparam int MAX_VERTICES_DEF = 6;
	localparam int COORD_BITS_DEF   = 11;
	localparam int MIN_VERTICES     = 3;

	localparam int WEIGHT_BITS      = 7;
	localparam int SUM_BITS         = 10;
	localparam int DIV_BITS         = 8;
	localparam int RND_BITS         = 7;
	localparam int COUNT_BITS       = 3;
	localparam int VSEL_BITS        = 3;
	localparam int PIX_BITS         = 11;
	localparam int CFG_ADDR_BITS    = 3;
	localparam int SUM_LO           = 99;
	localparam int SUM_HI           = 100;

	localparam int IN_TDATA_BITS    = 8;
	localparam int OUT_TDATA_BITS   = 32;
	localparam int OUT_TUSER_BITS   = 2;

	localparam logic [CFG_ADDR_BITS-1:0] REG_COUNT   = 3'd6;
	localparam logic [CFG_ADDR_BITS-1:0] REG_DIVISOR = 3'd7;

	localparam logic [COUNT_BITS-1:0] COUNT_RESET   = 3'd3;
	localparam logic [DIV_BITS-1:0]   DIVISOR_RESET = 8'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_CHECK,
		ST_XSTART,
		ST_XWAIT,
		ST_YSTART,
		ST_YWAIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                 bad_weights;
		logic                 off_image;
		logic [VSEL_BITS-1:0] chosen_vertex;
		logic [PIX_BITS-1:0]  pixel_y;
		logic [PIX_BITS-1:0]  pixel_x;
	} result_t;

endpackage

// ===== src/chaos_game_point_step.sv =====
// Channel   Dir  Fields (tdata / tuser, lowest bit first)
// s_*       in   tdata: random_value[6:0], pad ; tuser: restart
// m_*       out  tdata: pixel_x[10:0], pixel_y[21:11], chosen_vertex[24:22], pad
//                tuser: off_image, bad_weights
// cfg_*     in   cfg_addr 0-5 vertices, 6 vertex_count, 7 step_divisor
//
// An item occupies the core for the weight walk over the vertices, then for
// the shared divider, one quotient bit per cycle, for x and again for y.
// A request with bad weights skips the divider.
// Reset clears the point and the started mark; vertex registers go to zero,
// vertex_count to 3 and step_divisor to 2.
// The result sits in an output register; the core only waits if that register
// is still full and m_tready is low when the next result is ready.
module chaos_game_point_step
	import cgps_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int COORD_BITS   = COORD_BITS_DEF,
	localparam int VTX_BITS    = 2 * COORD_BITS + WEIGHT_BITS,
	localparam int IDX_BITS    = $clog2(MAX_VERTICES)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [IN_TDATA_BITS-1:0]  s_tdata,   // random_value[6:0], zero pad
	input  logic                      s_tuser,   // restart
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [OUT_TDATA_BITS-1:0] m_tdata,   // pixel_x, pixel_y, chosen_vertex, zero pad
	output logic [OUT_TUSER_BITS-1:0] m_tuser,   // off_image, bad_weights
	input  logic                      cfg_we,
	input  logic [CFG_ADDR_BITS-1:0]  cfg_addr,
	input  logic [VTX_BITS-1:0]       cfg_wdata
);

	logic [IDX_BITS-1:0] rd_idx;
	logic [VTX_BITS-1:0] rd_vertex;
	logic [VTX_BITS-1:0] vertex0;
	logic [IDX_BITS-1:0] last_idx;
	logic [DIV_BITS-1:0] divisor;
	logic                res_valid;
	logic                res_ready;
	result_t             res;

	logic                m_tvalid_q;
	result_t             out_q;

	cgps_cfg_regs #(
		.MAX_VERTICES (MAX_VERTICES),
		.COORD_BITS   (COORD_BITS)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.rd_idx    (rd_idx),
		.rd_vertex (rd_vertex),
		.vertex0   (vertex0),
		.last_idx  (last_idx),
		.divisor   (divisor)
	);

	cgps_core #(
		.MAX_VERTICES (MAX_VERTICES),
		.COORD_BITS   (COORD_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_rnd     (s_tdata[RND_BITS-1:0]),
		.in_restart (s_tuser),
		.rd_idx     (rd_idx),
		.rd_vertex  (rd_vertex),
		.vertex0    (vertex0),
		.last_idx   (last_idx),
		.divisor    (divisor),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_TDATA_BITS'({out_q.chosen_vertex, out_q.pixel_y, out_q.pixel_x});
	assign m_tuser  = {out_q.bad_weights, out_q.off_image};

endmodule

// ===== src/cgps_cfg_regs.sv =====
module cgps_cfg_regs
	import cgps_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int COORD_BITS   = COORD_BITS_DEF,
	localparam int VTX_BITS    = 2 * COORD_BITS + WEIGHT_BITS,
	localparam int IDX_BITS    = $clog2(MAX_VERTICES)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
	input  logic [VTX_BITS-1:0]      cfg_wdata,
	input  logic [IDX_BITS-1:0]      rd_idx,
	output logic [VTX_BITS-1:0]      rd_vertex,
	output logic [VTX_BITS-1:0]      vertex0,
	output logic [IDX_BITS-1:0]      last_idx,
	output logic [DIV_BITS-1:0]      divisor
);

	logic [VTX_BITS-1:0]   vtx_q [MAX_VERTICES];
	logic [COUNT_BITS-1:0] count_q;
	logic [DIV_BITS-1:0]   div_q;
	logic [COUNT_BITS-1:0] count_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_VERTICES; i++) begin
				vtx_q[i] <= '0;
			end
			count_q <= COUNT_RESET;
			div_q   <= DIVISOR_RESET;
		end else if (cfg_we) begin
			if (int'(cfg_addr) < MAX_VERTICES) begin
				vtx_q[cfg_addr[IDX_BITS-1:0]] <= cfg_wdata;
			end else if (cfg_addr == REG_COUNT) begin
				count_q <= cfg_wdata[COUNT_BITS-1:0];
			end else if (cfg_addr == REG_DIVISOR) begin
				div_q <= cfg_wdata[DIV_BITS-1:0];
			end
		end
	end

	// count is clamped into the supported range, divisor zero acts as one
	always_comb begin
		if (count_q < COUNT_BITS'(MIN_VERTICES)) begin
			count_eff = COUNT_BITS'(MIN_VERTICES);
		end else if (int'(count_q) > MAX_VERTICES) begin
			count_eff = COUNT_BITS'(MAX_VERTICES);
		end else begin
			count_eff = count_q;
		end
	end

	assign last_idx  = IDX_BITS'(count_eff - COUNT_BITS'(1));
	assign divisor   = (div_q == '0) ? DIV_BITS'(1) : div_q;
	assign rd_vertex = vtx_q[rd_idx];
	assign vertex0   = vtx_q[0];

endmodule

// ===== src/cgps_divider.sv =====
module cgps_divider
	import cgps_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	localparam int CNT_BITS  = $clog2(COORD_BITS + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [COORD_BITS-1:0] dividend,
	input  logic [DIV_BITS-1:0]   divisor,
	output logic [COORD_BITS-1:0] quotient,
	output logic                  done
);

	logic [CNT_BITS-1:0]   cnt_q;
	logic                  done_q;
	logic [DIV_BITS-1:0]   rem_q;
	logic [DIV_BITS-1:0]   div_q;
	logic [COORD_BITS-1:0] quo_q;

	logic [DIV_BITS:0]     trial;
	logic [DIV_BITS:0]     trial_sub;
	logic                  ge;
	logic [DIV_BITS-1:0]   rem_nx;

	// restoring division, one quotient bit per cycle; dividend bits shift
	// out of the top of quo_q while quotient bits shift in at the bottom
	assign trial     = {rem_q, quo_q[COORD_BITS-1]};
	assign trial_sub = trial - {1'b0, div_q};
	assign ge        = (trial >= {1'b0, div_q});
	assign rem_nx    = ge ? trial_sub[DIV_BITS-1:0] : trial[DIV_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_BITS'(COORD_BITS);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - CNT_BITS'(1);
				done_q <= (cnt_q == CNT_BITS'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= rem_nx;
			quo_q <= {quo_q[COORD_BITS-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

// ===== src/cgps_core.sv =====
module cgps_core
	import cgps_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int COORD_BITS   = COORD_BITS_DEF,
	localparam int VTX_BITS    = 2 * COORD_BITS + WEIGHT_BITS,
	localparam int IDX_BITS    = $clog2(MAX_VERTICES)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [RND_BITS-1:0]  in_rnd,
	input  logic                 in_restart,
	output logic [IDX_BITS-1:0]  rd_idx,
	input  logic [VTX_BITS-1:0]  rd_vertex,
	input  logic [VTX_BITS-1:0]  vertex0,
	input  logic [IDX_BITS-1:0]  last_idx,
	input  logic [DIV_BITS-1:0]  divisor,
	output logic                 res_valid,
	input  logic                 res_ready,
	output result_t              res
);

	localparam int EXT_BITS = (COORD_BITS > PIX_BITS) ? COORD_BITS : PIX_BITS;

	state_t                state_q;
	state_t                state_nx;

	logic                  started_q;
	logic [COORD_BITS-1:0] cx_q;
	logic [COORD_BITS-1:0] cy_q;
	logic [IDX_BITS-1:0]   k_q;
	logic [RND_BITS-1:0]   rnd_q;
	logic                  restart_q;
	logic [SUM_BITS-1:0]   sum_q;
	logic                  found_q;
	logic [IDX_BITS-1:0]   chosen_q;
	logic                  bad_q;
	logic                  neg_q;

	logic [WEIGHT_BITS-1:0] w_rd;
	logic [COORD_BITS-1:0]  vx_rd;
	logic [COORD_BITS-1:0]  vy_rd;
	logic [SUM_BITS-1:0]    run;
	logic                   hit;
	logic                   sum_bad;
	logic                   axis_y;
	logic [COORD_BITS-1:0]  cur;
	logic [COORD_BITS-1:0]  tgt;
	logic [COORD_BITS:0]    diff;
	logic [COORD_BITS:0]    diff_neg;
	logic [COORD_BITS-1:0]  mag;
	logic [COORD_BITS-1:0]  upd;
	logic                   div_start;
	logic [COORD_BITS-1:0]  quotient;
	logic                   div_done;
	logic [COORD_BITS-1:0]  px_m1;
	logic [COORD_BITS-1:0]  py_m1;
	logic [EXT_BITS-1:0]    px_ext;
	logic [EXT_BITS-1:0]    py_ext;

	assign w_rd  = rd_vertex[VTX_BITS-1 -: WEIGHT_BITS];
	assign vx_rd = rd_vertex[COORD_BITS-1:0];
	assign vy_rd = rd_vertex[2*COORD_BITS-1:COORD_BITS];

	assign rd_idx  = (state_q == ST_SUM) ? k_q : chosen_q;
	assign run     = sum_q + SUM_BITS'(w_rd);
	assign hit     = (SUM_BITS'(rnd_q) <= run);
	assign sum_bad = (sum_q < SUM_BITS'(SUM_LO)) || (sum_q > SUM_BITS'(SUM_HI));

	// one subtract / magnitude / update path shared by both coordinates
	assign axis_y   = (state_q == ST_YSTART) || (state_q == ST_YWAIT);
	assign cur      = axis_y ? cy_q : cx_q;
	assign tgt      = axis_y ? vy_rd : vx_rd;
	assign diff     = {1'b0, tgt} - {1'b0, cur};
	assign diff_neg = -diff;
	assign mag      = diff[COORD_BITS] ? diff_neg[COORD_BITS-1:0] : diff[COORD_BITS-1:0];
	assign upd      = neg_q ? (cur - quotient) : (cur + quotient);

	cgps_divider #(
		.COORD_BITS (COORD_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag),
		.divisor  (divisor),
		.quotient (quotient),
		.done     (div_done)
	);

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_nx = ST_SUM;
			ST_SUM:    if (k_q == last_idx) state_nx = ST_CHECK;
			ST_CHECK:  state_nx = sum_bad ? ST_DONE : ST_XSTART;
			ST_XSTART: state_nx = ST_XWAIT;
			ST_XWAIT:  if (div_done) state_nx = ST_YSTART;
			ST_YSTART: state_nx = ST_YWAIT;
			ST_YWAIT:  if (div_done) state_nx = ST_DONE;
			ST_DONE:   if (res_ready) state_nx = ST_IDLE;
			default:   state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		res_valid = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			ST_IDLE:   in_ready  = 1'b1;
			ST_XSTART: div_start = 1'b1;
			ST_YSTART: div_start = 1'b1;
			ST_DONE:   res_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			started_q <= 1'b0;
			cx_q      <= '0;
			cy_q      <= '0;
			k_q       <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_IDLE) begin
				k_q <= '0;
			end else if (state_q == ST_SUM) begin
				k_q <= k_q + IDX_BITS'(1);
			end
			// bad weights leave the point and the started mark alone
			if (state_q == ST_CHECK && !sum_bad && (restart_q || !started_q)) begin
				cx_q      <= vertex0[COORD_BITS-1:0];
				cy_q      <= vertex0[2*COORD_BITS-1:COORD_BITS];
				started_q <= 1'b1;
			end
			if (state_q == ST_XWAIT && div_done) begin
				cx_q <= upd;
			end
			if (state_q == ST_YWAIT && div_done) begin
				cy_q <= upd;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			rnd_q     <= in_rnd;
			restart_q <= in_restart;
			sum_q     <= '0;
			found_q   <= 1'b0;
			chosen_q  <= last_idx;
		end
		if (state_q == ST_SUM) begin
			sum_q <= run;
			if (!found_q && hit) begin
				found_q  <= 1'b1;
				chosen_q <= k_q;
			end
		end
		if (state_q == ST_CHECK) begin
			bad_q <= sum_bad;
		end
		if (state_q == ST_XSTART || state_q == ST_YSTART) begin
			neg_q <= diff[COORD_BITS];
		end
	end

	assign px_m1  = cx_q - COORD_BITS'(1);
	assign py_m1  = cy_q - COORD_BITS'(1);
	assign px_ext = EXT_BITS'(px_m1);
	assign py_ext = EXT_BITS'(py_m1);

	always_comb begin
		res = '0;
		if (bad_q) begin
			res.bad_weights = 1'b1;
		end else begin
			res.chosen_vertex = VSEL_BITS'(chosen_q);
			if (cx_q == '0 || cy_q == '0) begin
				res.off_image = 1'b1;
			end else begin
				res.pixel_x = px_ext[PIX_BITS-1:0];
				res.pixel_y = py_ext[PIX_BITS-1:0];
			end
		end
	end

endmodule
